>>> rtl/tpt_pkg.sv
// Package for the tunnel peer table: constants, field structs, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
package tpt_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [15:0] MIN_HEADER_LEN = 16'd20;
    localparam logic [3:0] TUNNEL_VERSION = 4'd4;
    localparam logic [7:0] TUNNEL_PROTOCOL = 8'd47;
    localparam logic [15:0] RESET_TIMEOUT = 16'd50;
    localparam logic [7:0] RESET_INTERVAL = 8'd2;
    localparam logic [0:0] CFG_TIMEOUT = 1'd0;
    localparam logic [0:0] CFG_INTERVAL = 1'd1;
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic        cmd;
        logic [31:0] pkt_id;
        logic [15:0] packet_length;
        logic [3:0]  ip_version;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] verdict_id;
        logic        tunnel_added;
        logic        table_full;
        logic [31:0] peer_addr;
        logic        last;
    } out_item_t;

    // classified job from front to back
    typedef struct packed {
        logic        is_sweep;
        logic        is_tunnel;
        logic [31:0] pkt_id;
        logic [31:0] addr;
        logic [31:0] now;
    } job_t;
endpackage

>>> rtl/tunnel_peer_table_with_aging.sv
// Tunnel peer table with idle aging. Packets and ticks enter at the front, a
// two-entry queue decouples the table walker. A lookup or sweep holds the walker
// through pop, read setup, a scan of every slot and a finish step; a non-tunnel
// packet skips the scan and a quiet tick is never queued. Results are strobed on done
// and cannot be stalled. Reset (rst_n, async) clears clock, tick count and valid bits.
`timescale 1ns / 1ps
module tunnel_peer_table_with_aging import tpt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_item_t    item,
    output logic        busy,
    output logic        done,
    output out_item_t   result,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [15:0] timeout_reg;
    logic [7:0]  interval_reg;
    logic push, pop, q_full, q_empty;
    job_t fjob, bjob;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= RESET_TIMEOUT;
            interval_reg <= RESET_INTERVAL;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TIMEOUT)
                timeout_reg <= cfg_data;
            else if (cfg_index == CFG_INTERVAL)
                interval_reg <= cfg_data[7:0];
        end
    end

    tpt_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .q_full(q_full),
        .interval(interval_reg), .busy(busy), .push(push), .job(fjob)
    );

    tpt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .din(fjob), .pop(pop),
        .full(q_full), .empty(q_empty), .dout(bjob)
    );

    tpt_back u_back (
        .clk(clk), .rst_n(rst_n), .empty(q_empty), .job(bjob), .timeout(timeout_reg),
        .pop(pop), .done(done), .result(result)
    );
endmodule

>>> rtl/tpt_front.sv
// Front end: accepts transactions, checks headers, keeps the clock and sweep count.
// Depends on tpt_pkg.
`timescale 1ns / 1ps
module tpt_front import tpt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_item_t    item,
    input  logic        q_full,
    input  logic [7:0]  interval,
    output logic        busy,
    output logic        push,
    output job_t        job
);
    logic [31:0] now_reg;
    logic [7:0]  cnt_reg;
    logic [7:0]  cnt_inc;
    logic [7:0]  eff_int;
    logic        take;
    logic        tun;

    assign busy = q_full;
    assign take = start && !q_full;
    assign cnt_inc = cnt_reg + 8'd1;
    assign eff_int = (interval == 8'd0) ? 8'd1 : interval;
    assign tun = item.packet_length >= MIN_HEADER_LEN && item.ip_version == TUNNEL_VERSION
                 && item.ip_protocol == TUNNEL_PROTOCOL;

    always_comb
    begin
        push = 1'b0;
        job.is_sweep = item.cmd == CMD_TICK;
        job.is_tunnel = tun;
        job.pkt_id = item.pkt_id;
        job.addr = item.src_addr;
        job.now = (item.cmd == CMD_TICK) ? now_reg + 32'd1 : now_reg;
        if (take)
        begin
            if (item.cmd == CMD_PACKET)
                push = 1'b1;
            else
                push = cnt_inc >= eff_int;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            cnt_reg <= '0;
        end
        else if (take && item.cmd == CMD_TICK)
        begin
            now_reg <= now_reg + 32'd1;
            cnt_reg <= (cnt_inc >= eff_int) ? 8'd0 : cnt_inc;
        end
    end
endmodule

>>> rtl/tpt_queue.sv
// Short job queue between front and back.
// Depends on tpt_pkg.
`timescale 1ns / 1ps
module tpt_queue import tpt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t din,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t dout
);
    localparam int PW = $clog2(QDEPTH);
    job_t mem_reg [QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0] n_reg;

    assign full = n_reg == (PW+1)'(QDEPTH);
    assign empty = n_reg == '0;
    assign dout = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == PW'(QDEPTH - 1)) ? '0 : wp_reg + PW'(1);
            if (pop)
                rp_reg <= (rp_reg == PW'(QDEPTH - 1)) ? '0 : rp_reg + PW'(1);
            n_reg <= n_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

>>> rtl/tpt_back.sv
// Back end: walks the peer table for lookups and aging sweeps, emits results.
// Depends on tpt_pkg.
`timescale 1ns / 1ps
module tpt_back import tpt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  job_t        job,
    input  logic [15:0] timeout,
    output logic        pop,
    output logic        done,
    output out_item_t   result
);
    typedef enum logic [1:0] {S_IDLE, S_READ, S_SCAN, S_FIN} state_t;
    state_t state_reg;
    job_t job_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [31:0] addr_mem [TABLE_ENTRIES];
    logic [31:0] seen_mem [TABLE_ENTRIES];
    logic [31:0] addr_q, seen_q;
    logic [IDX_W-1:0] ridx_reg;
    logic hit_reg, free_found_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg;
    logic pend_reg;
    out_item_t pend_item_reg;
    logic wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0] wr_seen;
    logic [31:0] idle;
    logic last_idx;

    assign pop = state_reg == S_IDLE && !empty;
    assign idle = job_reg.now - seen_q;
    assign last_idx = ridx_reg == IDX_W'(TABLE_ENTRIES - 1);

    always_ff @(posedge clk)
    begin
        addr_q <= addr_mem[idx_reg];
        seen_q <= seen_mem[idx_reg];
        if (wr_en)
        begin
            seen_mem[wr_idx] <= wr_seen;
            if (!hit_reg)
                addr_mem[wr_idx] <= job_reg.addr;
        end
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_idx = hit_reg ? hit_idx_reg : free_idx_reg;
        wr_seen = job_reg.now;
        if (state_reg == S_FIN && !job_reg.is_sweep && job_reg.is_tunnel
            && (hit_reg || free_found_reg))
            wr_en = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            done <= 1'b0;
            result <= '0;
            job_reg <= '0;
            pend_reg <= 1'b0;
            pend_item_reg <= '0;
            idx_reg <= '0;
            ridx_reg <= '0;
            hit_reg <= 1'b0;
            free_found_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_idx_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        job_reg <= job;
                        idx_reg <= '0;
                        ridx_reg <= '0;
                        hit_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        pend_reg <= 1'b0;
                        state_reg <= (job.is_sweep || job.is_tunnel) ? S_READ : S_FIN;
                    end
                end
                S_READ:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (!last_idx)
                        idx_reg <= idx_reg + IDX_W'(1);
                    ridx_reg <= ridx_reg + IDX_W'(1);
                    if (job_reg.is_sweep)
                    begin
                        if (valid_reg[ridx_reg] && idle > {16'd0, timeout})
                        begin
                            valid_reg[ridx_reg] <= 1'b0;
                            if (pend_reg)
                            begin
                                done <= 1'b1;
                                result <= pend_item_reg;
                            end
                            pend_reg <= 1'b1;
                            pend_item_reg <= '{KIND_REMOVE, 32'd0, 1'b0, 1'b0, addr_q, 1'b0};
                        end
                    end
                    else if (valid_reg[ridx_reg])
                    begin
                        if (addr_q == job_reg.addr && !hit_reg)
                        begin
                            hit_reg <= 1'b1;
                            hit_idx_reg <= ridx_reg;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg <= ridx_reg;
                    end
                    if (last_idx)
                        state_reg <= S_FIN;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    if (job_reg.is_sweep)
                    begin
                        if (pend_reg)
                        begin
                            done <= 1'b1;
                            result <= '{KIND_REMOVE, 32'd0, 1'b0, 1'b0,
                                        pend_item_reg.peer_addr, 1'b1};
                        end
                    end
                    else
                    begin
                        done <= 1'b1;
                        result.result_kind <= KIND_VERDICT;
                        result.verdict_id <= job_reg.pkt_id;
                        result.last <= 1'b1;
                        result.tunnel_added <= job_reg.is_tunnel && !hit_reg && free_found_reg;
                        result.table_full <= job_reg.is_tunnel && !hit_reg && !free_found_reg;
                        result.peer_addr <= (job_reg.is_tunnel && !hit_reg) ? job_reg.addr : 32'd0;
                        if (job_reg.is_tunnel && !hit_reg && free_found_reg)
                            valid_reg[free_idx_reg] <= 1'b1;
                    end
                end
            endcase
        end
    end
endmodule

>>> tb/tunnel_peer_table_with_aging_tb.sv
// Testbench for tunnel_peer_table_with_aging: directed rows, then random packet/tick
// phases under several timeout and sweep settings, scored against a local table model.
// Depends on tpt_pkg and the tunnel_peer_table_with_aging RTL.
`timescale 1ns / 1ps
module tunnel_peer_table_with_aging_tb;
    import tpt_pkg::*;

    localparam int DRAIN_CYCLES = (QDEPTH + 1) * (TABLE_ENTRIES + 3) + 16;
    localparam int STALL_LIMIT = 20000;
    localparam int POOL_SIZE = 80;

    typedef struct {
        in_item_t  it;
        bit        typed;
        out_item_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    in_item_t    item;
    logic        busy;
    logic        done;
    out_item_t   result;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    tunnel_peer_table_with_aging u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // peer table shadow
    logic [15:0] idle_timeout;
    logic [7:0]  sweep_period;
    logic [31:0] clock_secs;
    logic [7:0]  ticks_since_sweep;
    bit          peer_valid [TABLE_ENTRIES];
    logic [31:0] peer_addr_tbl [TABLE_ENTRIES];
    logic [31:0] peer_seen [TABLE_ENTRIES];

    out_item_t   pending_results [$];
    logic [31:0] addr_pool [POOL_SIZE];
    int          errors, n_packets, n_ticks, n_removed, n_added, n_full, n_results;
    int          stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_err(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic out_item_t mk_result(logic kind, logic [31:0] id, logic added,
                                            logic full, logic [31:0] addr, logic lst);
        out_item_t r;
        r.result_kind = kind;
        r.verdict_id = id;
        r.tunnel_added = added;
        r.table_full = full;
        r.peer_addr = addr;
        r.last = lst;
        return r;
    endfunction

    task automatic table_reset();
        idle_timeout = RESET_TIMEOUT;
        sweep_period = RESET_INTERVAL;
        clock_secs = '0;
        ticks_since_sweep = '0;
        foreach (peer_valid[i]) peer_valid[i] = 0;
    endtask

    task automatic predict_transaction(input in_item_t it);
        int hit, free_slot, first;
        out_item_t r;
        hit = -1;
        free_slot = -1;
        if (it.cmd == CMD_PACKET)
        begin
            r = mk_result(KIND_VERDICT, it.pkt_id, 1'b0, 1'b0, '0, 1'b1);
            if (it.packet_length >= MIN_HEADER_LEN && it.ip_version == TUNNEL_VERSION &&
                it.ip_protocol == TUNNEL_PROTOCOL)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (peer_valid[i])
                    begin
                        if (peer_addr_tbl[i] == it.src_addr && hit < 0) hit = i;
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = i;
                    end
                end
                if (hit >= 0)
                begin
                    peer_seen[hit] = clock_secs;
                end
                else if (free_slot >= 0)
                begin
                    peer_valid[free_slot] = 1;
                    peer_addr_tbl[free_slot] = it.src_addr;
                    peer_seen[free_slot] = clock_secs;
                    r.tunnel_added = 1'b1;
                    r.peer_addr = it.src_addr;
                end
                else
                begin
                    r.table_full = 1'b1;
                    r.peer_addr = it.src_addr;
                end
            end
            pending_results.push_back(r);
            n_packets++;
        end
        else
        begin
            n_ticks++;
            clock_secs = clock_secs + 32'd1;
            ticks_since_sweep = ticks_since_sweep + 8'd1;
            if (ticks_since_sweep >= sweep_period)
            begin
                ticks_since_sweep = '0;
                first = pending_results.size();
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (peer_valid[i] && (clock_secs - peer_seen[i]) > {16'd0, idle_timeout})
                    begin
                        peer_valid[i] = 0;
                        pending_results.push_back(mk_result(KIND_REMOVE, '0, 1'b0, 1'b0,
                                                            peer_addr_tbl[i], 1'b0));
                    end
                end
                if (pending_results.size() > first)
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
        end
    endtask

    task automatic send(input in_item_t it);
        @(negedge clk);
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        predict_transaction(it);
    endtask

    task automatic pause(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_idle();
        pause(1);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TIMEOUT) idle_timeout = val;
        else sweep_period = val[7:0];
    endtask

    function automatic in_item_t rand_item(int pool_n);
        in_item_t it;
        int pick;
        it.cmd = CMD_PACKET;
        it.pkt_id = $urandom;
        it.packet_length = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(20, 65535))
                                                       : 16'($urandom_range(20, 64));
        it.ip_version = TUNNEL_VERSION;
        it.ip_protocol = TUNNEL_PROTOCOL;
        it.src_addr = addr_pool[$urandom_range(0, pool_n - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            it.cmd = CMD_TICK;
        end
        else if (pick < 26)
        begin
            it.packet_length = 16'($urandom);
            it.ip_version = 4'($urandom);
            it.ip_protocol = 8'($urandom);
            it.src_addr = $urandom;
        end
        else if (pick < 30)
        begin
            it.packet_length = 16'($urandom_range(0, 19));
        end
        return it;
    endfunction

    task automatic run_random(input int count, input int pool_n, input bit with_gaps);
        for (int k = 0; k < count; k++)
        begin
            send(rand_item(pool_n));
            if (with_gaps && $urandom_range(0, 3) == 0) pause($urandom_range(1, 12));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                report_err($sformatf("unexpected result %p", result));
            end
            else
            begin
                out_item_t want;
                want = pending_results.pop_front();
                if (result.result_kind !== want.result_kind)
                    report_err($sformatf("result_kind %b want %b", result.result_kind,
                                         want.result_kind));
                if (result.verdict_id !== want.verdict_id)
                    report_err($sformatf("verdict_id %h want %h",
                                         result.verdict_id, want.verdict_id));
                if (result.tunnel_added !== want.tunnel_added)
                    report_err($sformatf("tunnel_added %b want %b", result.tunnel_added,
                                         want.tunnel_added));
                if (result.table_full !== want.table_full)
                    report_err($sformatf("table_full %b want %b", result.table_full,
                                         want.table_full));
                if (result.peer_addr !== want.peer_addr)
                    report_err($sformatf("peer_addr %h want %h", result.peer_addr,
                                         want.peer_addr));
                if (result.last !== want.last)
                    report_err($sformatf("last %b want %b", result.last, want.last));
                if (want.result_kind == KIND_REMOVE) n_removed++;
                if (want.tunnel_added) n_added++;
                if (want.table_full) n_full++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic row_t pkt_row(logic [31:0] id, logic [15:0] len, logic [3:0] ver,
                                     logic [7:0] proto, logic [31:0] src, bit typed,
                                     logic added, logic [31:0] addr);
        row_t r;
        r.it = '{cmd: CMD_PACKET, pkt_id: id, packet_length: len, ip_version: ver,
                 ip_protocol: proto, src_addr: src};
        r.typed = typed;
        r.want = mk_result(KIND_VERDICT, id, added, 1'b0, addr, 1'b1);
        return r;
    endfunction

    initial
    begin
        row_t rows [$];
        row_t tick_row;
        errors = 0; n_packets = 0; n_ticks = 0; n_removed = 0;
        n_added = 0; n_full = 0; n_results = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        foreach (addr_pool[i]) addr_pool[i] = $urandom;
        table_reset();

        tick_row.it = '0;
        tick_row.it.cmd = CMD_TICK;
        tick_row.it.pkt_id = 32'hFFFF_FFFF;
        tick_row.typed = 0;
        rows.push_back(pkt_row(32'h0, 16'h0, 4'h0, 8'h0, 32'h0, 1, 1'b0, '0));
        rows.push_back(pkt_row(32'hFFFF_FFFF, 16'hFFFF, 4'hF, 8'hFF, 32'hFFFF_FFFF, 1, 1'b0,
                               '0));
        rows.push_back(pkt_row(32'h11, 16'd19, TUNNEL_VERSION, TUNNEL_PROTOCOL, 32'h1, 1,
                               1'b0, '0));
        rows.push_back(pkt_row(32'h12, 16'd20, TUNNEL_VERSION, TUNNEL_PROTOCOL,
                               32'hFFFF_FFFF, 1, 1'b1, 32'hFFFF_FFFF));
        rows.push_back(pkt_row(32'h13, 16'hFFFF, TUNNEL_VERSION, TUNNEL_PROTOCOL,
                               32'hFFFF_FFFF, 1, 1'b0, '0));
        rows.push_back(pkt_row(32'h14, 16'd100, 4'd5, TUNNEL_PROTOCOL, 32'h2, 1, 1'b0, '0));
        rows.push_back(pkt_row(32'h15, 16'd100, TUNNEL_VERSION, 8'd46, 32'h3, 1, 1'b0, '0));
        rows.push_back(pkt_row(32'h16, 16'hFFFF, TUNNEL_VERSION, TUNNEL_PROTOCOL, 32'h0, 1,
                               1'b1, 32'h0));
        rows.push_back(pkt_row(32'h17, 16'd40, TUNNEL_VERSION, TUNNEL_PROTOCOL,
                               32'h0A00_0001, 0, 1'b0, '0));
        rows.push_back(tick_row);
        rows.push_back(tick_row);
        rows.push_back(pkt_row(32'h18, 16'd40, TUNNEL_VERSION, TUNNEL_PROTOCOL,
                               32'h0A00_0001, 0, 1'b0, '0));
        rows.push_back(tick_row);
        rows.push_back(pkt_row(32'h19, 16'd1500, TUNNEL_VERSION, TUNNEL_PROTOCOL,
                               32'hC0A8_0101, 0, 1'b0, '0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            send(rows[i].it);
            if (rows[i].typed)
            begin
                void'(pending_results.pop_back());
                pending_results.push_back(rows[i].want);
            end
            if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 12));
        end

        // long timeout, slow sweeps: table fills up
        wait_idle();
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        write_reg(CFG_INTERVAL, 16'd255);
        run_random(110, POOL_SIZE, 1);

        // interval drops below the tick count, zero timeout ages everything
        wait_idle();
        write_reg(CFG_TIMEOUT, 16'd0);
        write_reg(CFG_INTERVAL, 16'd1);
        run_random(60, 24, 1);

        wait_idle();
        write_reg(CFG_TIMEOUT, 16'd3);
        write_reg(CFG_INTERVAL, 16'd0);
        run_random(66, 8, 0);

        pause(1);
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d packets and %0d ticks: %0d peers added, %0d refused as full,",
                 n_packets, n_ticks, n_added, n_full);
        $display("%0d removed by aging, %0d results checked, %0d mismatches",
                 n_removed, n_results, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
